@@ rtl/mbhp_pkg.sv @@
package mbhp_pkg;

  // Sizes fixed by the item and register formats.
  localparam int unsigned ChanW    = 3;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned FracW    = 30;
  localparam int unsigned ProdW    = 2 * DataW;
  // Five products of up to 2^62 magnitude plus the rounding bias.
  localparam int unsigned SumW     = ProdW + 3;

  localparam int unsigned NumChannelsDef = 5;

  localparam logic signed [DataW-1:0] CoefB0Rst = 32'sd1061830421;
  localparam logic signed [DataW-1:0] CoefB1Rst = -32'sd2123660004;
  localparam logic signed [DataW-1:0] CoefB2Rst = 32'sd1061830421;
  localparam logic signed [DataW-1:0] CoefA1Rst = 32'sd2123527864;
  localparam logic signed [DataW-1:0] CoefA2Rst = -32'sd1050051160;
  localparam logic [ShiftW-1:0]       ShiftRst  = 5'd15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoefB0     = 3'd0,
    CfgCoefB1     = 3'd1,
    CfgCoefB2     = 3'd2,
    CfgCoefA1     = 3'd3,
    CfgCoefA2     = 3'd4,
    CfgInputShift = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] b0;
    logic signed [DataW-1:0] b1;
    logic signed [DataW-1:0] b2;
    logic signed [DataW-1:0] a1;
    logic signed [DataW-1:0] a2;
  } coef_set_t;

  // One channel's filter history, as held in one memory word.
  typedef struct packed {
    logic signed [DataW-1:0] x1;
    logic signed [DataW-1:0] x2;
    logic signed [DataW-1:0] y1;
    logic signed [DataW-1:0] y2;
  } hist_t;

  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } stage_en_t;

endpackage

@@ rtl/mbhp_mac.sv @@
module mbhp_mac (
  input  logic                                clk_i,
  input  mbhp_pkg::stage_en_t                 en_i,
  input  mbhp_pkg::coef_set_t                 coef_i,
  input  logic signed [mbhp_pkg::DataW-1:0]   x_i,
  input  mbhp_pkg::hist_t                     hist_i,
  output logic signed [mbhp_pkg::SumW-1:0]    sum_o
);
  import mbhp_pkg::*;

  localparam logic signed [SumW-1:0] RoundBias = SumW'(64'sd1 <<< (FracW - 1));

  logic signed [ProdW-1:0] prod_d [5];
  logic signed [ProdW-1:0] prod_q [5];
  logic signed [SumW-1:0]  sum_d;
  logic signed [SumW-1:0]  sum_q;

  always_comb begin
    prod_d[0] = ProdW'(coef_i.b0) * ProdW'(x_i);
    prod_d[1] = ProdW'(coef_i.b1) * ProdW'(hist_i.x1);
    prod_d[2] = ProdW'(coef_i.b2) * ProdW'(hist_i.x2);
    prod_d[3] = ProdW'(coef_i.a1) * ProdW'(hist_i.y1);
    prod_d[4] = ProdW'(coef_i.a2) * ProdW'(hist_i.y2);
  end

  // Exact sum of the Q4.60 products; the bias makes the later floor round half up.
  always_comb begin
    sum_d = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2])
          + SumW'(prod_q[3]) + SumW'(prod_q[4]) + RoundBias;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load_prod) begin
      prod_q <= prod_d;
    end
    if (en_i.load_sum) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ rtl/multichannel_biquad_highpass_top.sv @@
// Multichannel direct-form-1 biquad highpass. Each input item carries a channel number and a
// raw unsigned 16-bit ADC sample; the sample is scaled into signed Q2.30 by a left shift of
// (30 - input_shift) and saturated (an input_shift of 31 shifts right by one), then filtered
// as y = b0*x + b1*x1 + b2*x2 + a1*y1 + a2*y2 with the feedback terms added, rounded half up
// to Q2.30 and saturated. One result item comes out for every input item, in order. Items of
// different channels are accepted one per clock while the output is not stalled, and each
// result passes the first stage (history read), the second (products), the third (sum) and
// the output register. Each channel's history sits in one word of a single history memory,
// read when the item is accepted and written back when the result leaves the last stage; an
// item whose channel is still in flight waits at the input until the loop from the memory
// read through the multipliers, the adder and the saturation to the memory write is closed. The
// history reads as zero after reset by way of one valid bit per channel, so no clearing pass
// is needed. A channel number at or above NUM_CHANNELS still yields an item, with a filtered
// value of zero, and touches no history. Coefficients and the input shift are written through
// the configuration port and must only change while no item is in flight.
module multichannel_biquad_highpass_top #(
  parameter int unsigned NUM_CHANNELS = mbhp_pkg::NumChannelsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mbhp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mbhp_pkg::DataW-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mbhp_pkg::ChanW-1:0]         channel_i,
  input  logic [mbhp_pkg::SampleW-1:0]       sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mbhp_pkg::ChanW-1:0]         out_channel_o,
  output logic signed [mbhp_pkg::DataW-1:0]  filtered_o
);
  import mbhp_pkg::*;

  localparam int unsigned AddrW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned WideW = SampleW + FracW;

  // Configuration registers.
  coef_set_t         coef_q;
  logic [ShiftW-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= CoefB0Rst;
      coef_q.b1 <= CoefB1Rst;
      coef_q.b2 <= CoefB2Rst;
      coef_q.a1 <= CoefA1Rst;
      coef_q.a2 <= CoefA2Rst;
      shift_q   <= ShiftRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCoefB0:     coef_q.b0 <= cfg_wdata_i;
        CfgCoefB1:     coef_q.b1 <= cfg_wdata_i;
        CfgCoefB2:     coef_q.b2 <= cfg_wdata_i;
        CfgCoefA1:     coef_q.a1 <= cfg_wdata_i;
        CfgCoefA2:     coef_q.a2 <= cfg_wdata_i;
        CfgInputShift: shift_q   <= cfg_wdata_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // Stage occupancy and flow control. A stage takes a new item when it is empty or when its
  // own item moves on in the same cycle.
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_free, en1, en2, en3;
  logic in_fire, hazard;

  logic [ChanW-1:0] s1_ch_q, s2_ch_q, s3_ch_q, out_ch_q;
  logic             s1_oob_q, s2_oob_q, s3_oob_q;

  assign out_free = !out_v_q || out_ready_i;
  assign en3      = !s3_v_q || out_free;
  assign en2      = !s2_v_q || en3;
  assign en1      = !s1_v_q || en2;

  // A channel that is still in flight has not written its history back yet.
  assign hazard = (s1_v_q && (s1_ch_q == channel_i)) ||
                  (s2_v_q && (s2_ch_q == channel_i)) ||
                  (s3_v_q && (s3_ch_q == channel_i));

  assign in_ready_o = en1 && !hazard;
  assign in_fire    = in_valid_i && in_ready_o;

  logic             in_oob;
  logic [AddrW-1:0] rd_addr;

  assign in_oob  = (32'(channel_i) >= NUM_CHANNELS);
  assign rd_addr = AddrW'(channel_i);

  // Input scaling into Q2.30, done ahead of the first stage register.
  logic [WideW-1:0]        x_wide;
  logic signed [DataW-1:0] x_in;

  always_comb begin
    if (shift_q > ShiftW'(FracW)) begin
      x_wide = WideW'(sample_i >> (shift_q - ShiftW'(FracW)));
    end else begin
      x_wide = WideW'(sample_i) << (ShiftW'(FracW) - shift_q);
    end
    if (|x_wide[WideW-1:DataW-1]) begin
      x_in = {1'b0, {(DataW-1){1'b1}}};
    end else begin
      x_in = {1'b0, x_wide[DataW-2:0]};
    end
  end

  // History memory: one word per channel, one read and one write port.
  hist_t            hist_mem_q [NUM_CHANNELS];
  hist_t            rd_data_q;
  logic             rd_vld_q;
  logic [NUM_CHANNELS-1:0] vld_q;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  hist_t            wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem_q[wr_addr] <= wr_data;
    end
    if (in_fire && !in_oob) begin
      rd_data_q <= hist_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_q <= !in_oob && vld_q[rd_addr];
      end
    end
  end

  // A channel never written since reset has an all-zero history.
  hist_t s1_hist;
  assign s1_hist = rd_vld_q ? rd_data_q : '0;

  logic signed [DataW-1:0] s1_x_q, s2_x_q, s3_x_q;
  logic signed [DataW-1:0] s2_x1_q, s3_x1_q, s2_y1_q, s3_y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= in_fire;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (out_free) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_ch_q  <= channel_i;
      s1_oob_q <= in_oob;
      s1_x_q   <= x_in;
    end
    if (en2) begin
      s2_ch_q  <= s1_ch_q;
      s2_oob_q <= s1_oob_q;
      s2_x_q   <= s1_x_q;
      s2_x1_q  <= s1_hist.x1;
      s2_y1_q  <= s1_hist.y1;
    end
    if (en3) begin
      s3_ch_q  <= s2_ch_q;
      s3_oob_q <= s2_oob_q;
      s3_x_q   <= s2_x_q;
      s3_x1_q  <= s2_x1_q;
      s3_y1_q  <= s2_y1_q;
    end
  end

  // Products are registered in the second stage and their sum in the third.
  stage_en_t               mac_en;
  logic signed [SumW-1:0]  sum;

  assign mac_en.load_prod = en2;
  assign mac_en.load_sum  = en3;

  mbhp_mac u_mac (
    .clk_i  (clk_i),
    .en_i   (mac_en),
    .coef_i (coef_q),
    .x_i    (s1_x_q),
    .hist_i (s1_hist),
    .sum_o  (sum)
  );

  // Floor to Q2.30 and saturate: the value fits when every bit above the result's sign
  // agrees with it.
  logic signed [DataW-1:0] y_sat;

  always_comb begin
    if ((&sum[SumW-1:FracW+DataW-1]) || !(|sum[SumW-1:FracW+DataW-1])) begin
      y_sat = sum[FracW+DataW-1:FracW];
    end else if (sum[SumW-1]) begin
      y_sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  assign wr_en   = s3_v_q && out_free && !s3_oob_q;
  assign wr_addr = AddrW'(s3_ch_q);
  always_comb begin
    wr_data.x1 = s3_x_q;
    wr_data.x2 = s3_x1_q;
    wr_data.y1 = y_sat;
    wr_data.y2 = s3_y1_q;
  end

  logic signed [DataW-1:0] filt_q;

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_ch_q <= s3_ch_q;
      filt_q   <= s3_oob_q ? '0 : y_sat;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_channel_o = out_ch_q;
  assign filtered_o    = filt_q;

  // Two items of one channel are never in flight together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s2_v_q |-> s1_ch_q != s2_ch_q) and
    (s2_v_q && s3_v_q |-> s2_ch_q != s3_ch_q) and
    (s1_v_q && s3_v_q |-> s1_ch_q != s3_ch_q))
    else $error("two items of one channel in flight");

  // An accepted item always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_v_q)
    else $error("accepted item lost at the first stage");

  // A history write-back marks the channel valid and hands a result to the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (vld_q[$past(wr_addr)] && out_v_q))
    else $error("history write-back without valid bit or result");

endmodule

@@ test/tb_multichannel_biquad_highpass_top.sv @@
`timescale 1ns / 100ps

module tb_multichannel_biquad_highpass_top;

  import mbhp_pkg::*;

  localparam int unsigned FiltChans = NumChannelsDef;

  // Highpass coefficient set that the block comes out of reset with.
  localparam logic signed [31:0] HpB0 = 32'sd1061830421;
  localparam logic signed [31:0] HpB1 = -32'sd2123660004;
  localparam logic signed [31:0] HpB2 = 32'sd1061830421;
  localparam logic signed [31:0] HpA1 = 32'sd2123527864;
  localparam logic signed [31:0] HpA2 = -32'sd1050051160;
  localparam logic signed [31:0] CoefMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CoefMin = 32'sh8000_0000;

  typedef struct {
    logic [ChanW-1:0]        chan;
    logic signed [DataW-1:0] value;
  } filt_out_t;

  // Keeps its own copy of the coefficients and of every channel's history, and
  // queues the filter output that each accepted sample must produce.
  class hp_filter_checker;
    logic signed [31:0] b0, b1, b2, a1, a2;
    logic [4:0]         shift;
    logic signed [31:0] x1[FiltChans];
    logic signed [31:0] x2[FiltChans];
    logic signed [31:0] y1[FiltChans];
    logic signed [31:0] y2[FiltChans];
    filt_out_t          due_outputs[$];
    int                 mismatches;

    function new();
      b0 = HpB0;
      b1 = HpB1;
      b2 = HpB2;
      a1 = HpA1;
      a2 = HpA2;
      shift = 5'd15;
      foreach (x1[k]) begin
        x1[k] = '0;
        x2[k] = '0;
        y1[k] = '0;
        y2[k] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CfgCoefB0:     b0 = val;
        CfgCoefB1:     b1 = val;
        CfgCoefB2:     b2 = val;
        CfgCoefA1:     a1 = val;
        CfgCoefA2:     a2 = val;
        CfgInputShift: shift = val[4:0];
        default: ;
      endcase
    endfunction

    // Exact Q4.60 product, widened so that five of them sum without overflow.
    function logic signed [69:0] mac_term(logic signed [31:0] c, logic signed [31:0] d);
      longint p;
      p = longint'(c) * longint'(d);
      return p;
    endfunction

    function filt_out_t filter_step(logic [ChanW-1:0] ch, logic [SampleW-1:0] smp);
      filt_out_t          r;
      logic [46:0]        scaled;
      logic signed [31:0] xin;
      logic signed [69:0] acc;
      logic signed [69:0] q;
      r.chan  = ch;
      r.value = '0;
      // Channels past the last one produce a zero and leave all history alone.
      if (ch >= FiltChans) return r;
      if (shift <= 5'd30) scaled = {31'd0, smp} << (5'd30 - shift);
      else scaled = {31'd0, smp} >> (shift - 5'd30);
      xin = (scaled > 47'h7FFF_FFFF) ? CoefMax : signed'(scaled[31:0]);
      acc = mac_term(b0, xin) + mac_term(b1, x1[ch]) + mac_term(b2, x2[ch])
          + mac_term(a1, y1[ch]) + mac_term(a2, y2[ch]);
      // Round half up to Q2.30, then clamp to the 32-bit range.
      acc = acc + 70'sd536870912;
      q = acc >>> 30;
      if (q > 70'sd2147483647) r.value = CoefMax;
      else if (q < -70'sd2147483648) r.value = CoefMin;
      else r.value = q[31:0];
      x2[ch] = x1[ch];
      x1[ch] = xin;
      y2[ch] = y1[ch];
      y1[ch] = r.value;
      return r;
    endfunction

    function void note_sample(logic [ChanW-1:0] ch, logic [SampleW-1:0] smp);
      due_outputs.push_back(filter_step(ch, smp));
    endfunction

    function int outstanding();
      return due_outputs.size();
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_output(logic [ChanW-1:0] ch, logic signed [DataW-1:0] val);
      filt_out_t exp_out;
      if (due_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected item, channel %0d value %0d", ch, val));
        return;
      end
      exp_out = due_outputs.pop_front();
      if (ch !== exp_out.chan)
        report_mismatch($sformatf("out_channel %0d, expected %0d", ch, exp_out.chan));
      if (val !== exp_out.value)
        report_mismatch($sformatf("filtered %0d on channel %0d, expected %0d",
                                  val, exp_out.chan, exp_out.value));
    endtask
  endclass

  // Every input of the block starts at a known value.
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i   = '0;
  logic [DataW-1:0]          cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [ChanW-1:0]          channel_i   = '0;
  logic [SampleW-1:0]        sample_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [ChanW-1:0]          out_channel_o;
  logic signed [DataW-1:0]   filtered_o;

  hp_filter_checker sb;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  multichannel_biquad_highpass_top #(
    .NUM_CHANNELS(FiltChans)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_channel_o (out_channel_o),
    .filtered_o    (filtered_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // The run must finish well inside this time; if it does not, something hangs.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // The receiver decides each cycle whether to take an item. All signals are
  // sampled at the rising edge, before any of this edge's updates land.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_output(out_channel_o, filtered_o);
  end

  // Presents one sample and holds it until the block takes it. The valid line
  // is only dropped when a gap follows or when the caller marks the last item,
  // so back-to-back items keep valid high without a glitch.
  task automatic send_item(logic [ChanW-1:0] ch, logic [SampleW-1:0] smp, bit last);
    int gap;
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(ch, smp);
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (last || gap > 0) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Coefficients and shift may only change with nothing in flight, so every
  // new setting waits for the last expected item to come out first.
  task automatic reconfigure(logic signed [31:0] nb0, logic signed [31:0] nb1,
                             logic signed [31:0] nb2, logic signed [31:0] na1,
                             logic signed [31:0] na2, logic [4:0] nsh);
    wait_drained();
    write_reg(CfgCoefB0, nb0);
    write_reg(CfgCoefB1, nb1);
    write_reg(CfgCoefB2, nb2);
    write_reg(CfgCoefA1, na1);
    write_reg(CfgCoefA2, na2);
    write_reg(CfgInputShift, {27'd0, nsh});
    cfg_we_i <= 1'b0;
  endtask

  // Random samples over random channels. About a third of the items repeat the
  // previous channel so that same-channel items pile up behind the history
  // loop; about one in ten goes to a channel number the block does not filter.
  task automatic run_random_phase(int count);
    logic [ChanW-1:0]   ch;
    logic [SampleW-1:0] smp;
    int                 r;
    ch = '0;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r >= 30 && r < 40) ch = ChanW'($urandom_range(7, FiltChans));
      else if (r >= 40) ch = ChanW'($urandom_range(FiltChans - 1, 0));
      r = $urandom_range(99);
      if (r < 8) smp = 16'h0000;
      else if (r < 16) smp = 16'hFFFF;
      else smp = 16'($urandom);
      send_item(ch, smp, i == count - 1);
    end
  endtask

  function automatic logic signed [31:0] rand_coef(int unsigned mag_bits);
    logic signed [31:0] c;
    c = 32'($urandom);
    if (mag_bits < 32) c = c >>> (32 - mag_bits);
    return c;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    return $urandom_range(1) ? CoefMax : CoefMin;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned sh;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items, first with the reset coefficients and a shift of 15.
    // Zero and full-scale samples, the same channel back to back, every
    // channel, and the three channel numbers past the last filtered one.
    send_item(3'd0, 16'h0000, 1'b0);
    send_item(3'd0, 16'hFFFF, 1'b0);
    send_item(3'd0, 16'hFFFF, 1'b0);
    send_item(3'd0, 16'h0000, 1'b0);
    send_item(3'd1, 16'h0001, 1'b0);
    send_item(3'd2, 16'h8000, 1'b0);
    send_item(3'd3, 16'hAAAA, 1'b0);
    send_item(3'd4, 16'h5555, 1'b0);
    send_item(3'd4, 16'hFFFF, 1'b0);
    send_item(3'd5, 16'h1234, 1'b0);
    send_item(3'd6, 16'hFFFF, 1'b0);
    send_item(3'd7, 16'h0000, 1'b1);

    // No shift at all saturates the scaled sample, and the extreme
    // coefficients drive the sum past both ends of the output range.
    reconfigure(CoefMax, CoefMin, CoefMax, CoefMax, CoefMin, 5'd0);
    send_item(3'd0, 16'hFFFF, 1'b0);
    send_item(3'd0, 16'hFFFF, 1'b0);
    send_item(3'd0, 16'h0000, 1'b0);
    send_item(3'd1, 16'hFFFF, 1'b1);
    reconfigure(CoefMin, CoefMin, CoefMin, CoefMin, CoefMin, 5'd16);
    send_item(3'd2, 16'hFFFF, 1'b0);
    send_item(3'd2, 16'hFFFF, 1'b0);
    send_item(3'd2, 16'h0001, 1'b1);

    // A shift of 31 scales the sample down instead of up; 30 leaves it as is.
    reconfigure(HpB0, HpB1, HpB2, HpA1, HpA2, 5'd31);
    send_item(3'd3, 16'hFFFF, 1'b0);
    send_item(3'd3, 16'h0001, 1'b0);
    send_item(3'd4, 16'h0000, 1'b1);
    reconfigure(HpB0, HpB1, HpB2, HpA1, HpA2, 5'd30);
    send_item(3'd0, 16'hFFFF, 1'b1);

    // Random phases. The idle pattern cycles through no idling, a slow sender,
    // a slow receiver and both a little slow; the settings go through the
    // highpass set, fully random, small stable-looking and extreme ones.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 47;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 47;
        end
        default: begin
          tx_idle_pct = 9;
          rx_stall_pct = 9;
        end
      endcase
      case ((phase / 2) % 4)
        0: reconfigure(HpB0, HpB1, HpB2, HpA1, HpA2, 5'($urandom_range(16, 12)));
        1: reconfigure(rand_coef(32), rand_coef(32), rand_coef(32), rand_coef(32),
                       rand_coef(32), 5'($urandom_range(31, 0)));
        2: reconfigure(rand_coef(30), rand_coef(30), rand_coef(30), rand_coef(30),
                       rand_coef(29), 5'($urandom_range(16, 8)));
        default: begin
          sh = $urandom_range(2);
          reconfigure(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), (sh == 0) ? 5'd0 : (sh == 1) ? 5'd16 : 5'd31);
        end
      endcase
      run_random_phase(135);
    end

    // Let the last items come out, then allow a few more cycles in case the
    // block produces anything it should not.
    rx_stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
